FILE: hdl/rbmf_pkg.sv
// Shared constants, controller/datapath interface types and small helper
// functions for the RGB box mean filter.
// No dependencies.
package rbmf_pkg;

  localparam int MAX_LINE   = 2048;
  localparam int MAX_RADIUS = 7;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int MEM_DEPTH  = RING_ROWS * MAX_LINE;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 14;
  localparam int ADDR_W     = 15;
  localparam int SUM_W      = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic check;
    logic start_win;
    logic acc;
    logic div_load;
    logic div_step;
    logic finish;
    logic adv_in;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_ok;
    logic out_ready;
    logic tap_last;
    logic div_last;
    logic out_busy;
    logic res_last;
  } stat_t;

  // Row modulo the ring depth of fifteen, by summing hex digits.
  function automatic logic [3:0] mod15(input logic [12:0] v);
    logic [5:0] s;
    s = {2'b0, v[3:0]} + {2'b0, v[7:4]} + {2'b0, v[11:8]} + {5'b0, v[12]};
    if (s >= 6'd30) s = s - 6'd30;
    if (s >= 6'd15) s = s - 6'd15;
    return s[3:0];
  endfunction

  // True when the window of output (oc, orow) is complete given the input position.
  function automatic logic win_ready(input logic [ROW_W-1:0] orow,
                                     input logic [COL_W-1:0] oc,
                                     input logic [ROW_W-1:0] ir,
                                     input logic [COL_W-1:0] ic,
                                     input logic [2:0] r,
                                     input logic [COL_W-1:0] wm1);
    logic [ROW_W:0] nr;
    logic [COL_W:0] nc;
    nr = {1'b0, orow} + {12'b0, r};
    nc = {1'b0, oc} + {9'b0, r};
    if (nc > {1'b0, wm1}) nc = {1'b0, wm1};
    return (nr < {1'b0, ir}) || ((nr == {1'b0, ir}) && (nc <= {1'b0, ic}));
  endfunction

endpackage

FILE: hdl/rbmf_divider.sv
// Restoring divider, one quotient bit per step, for one colour channel.
// Depends on rbmf_pkg.
module rbmf_divider (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [rbmf_pkg::SUM_W-1:0] dividend,
  input  logic [7:0]                divisor,
  output logic [7:0]                quotient
);
  import rbmf_pkg::*;

  logic [SUM_W-1:0] quo;
  logic [7:0]       rem;
  logic [8:0]       trial;

  assign trial    = {rem, quo[SUM_W-1]};
  assign quotient = quo[7:0];

  // Shift in one dividend bit and subtract the divisor where it fits.
  always_ff @(posedge clk) begin
    if (load) begin
      quo <= dividend;
      rem <= 8'd0;
    end else if (step) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= 8'(trial - {1'b0, divisor});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[7:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/rbmf_ctrl.sv
// Controller state machine of the box mean filter: sequences item check,
// window accumulation, division and result hand-off. Depends on rbmf_pkg.
module rbmf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rbmf_pkg::stat_t stat,
  output rbmf_pkg::cmd_t  cmd
);
  import rbmf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHK   = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_RADDR = 3'd3;
  localparam logic [2:0] ST_RACC  = 3'd4;
  localparam logic [2:0] ST_DLOAD = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state, state_next;

  assign in_stall = (state != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.check  = 1'b1;
        state_next = stat.item_ok ? ST_EVAL : ST_IDLE;
      end
      ST_EVAL: begin
        if (stat.out_ready) begin
          cmd.start_win = 1'b1;
          state_next    = ST_RADDR;
        end else begin
          cmd.adv_in = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RADDR: state_next = ST_RACC;
      ST_RACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.tap_last ? ST_DLOAD : ST_RADDR;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = stat.res_last ? ST_IDLE : ST_EVAL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/rbmf_datapath.sv
// Datapath of the box mean filter: configuration, position counters, line
// store, window accumulators, dividers and output register. Depends on rbmf_pkg.
module rbmf_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  rbmf_pkg::cmd_t        cmd,
  output rbmf_pkg::stat_t       stat,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [12:0]           cfg_data,
  input  logic                  cmd_in,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  output logic                  last_of_run,
  output logic                  frame_done
);
  import rbmf_pkg::*;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  window_radius;

  logic [COL_W-1:0] wm1;
  logic [12:0]      hm1;
  logic [3:0]       side_m1;
  logic [3:0]       side;
  logic [7:0]       area;

  logic [COL_W-1:0] in_col, out_col;
  logic [ROW_W-1:0] in_row, out_row;
  logic [2:0]       nres;

  logic        item_flush;
  logic [23:0] item_pix;

  logic [23:0] mem [0:MEM_DEPTH-1];
  logic [23:0] mem_q;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  logic [3:0] tx, ty;
  logic [SUM_W-1:0] sum_b, sum_g, sum_r;
  logic [3:0] div_cnt;
  logic [7:0] q_b, q_g, q_r;

  logic signed [15:0] ys;
  logic signed [12:0] xs;
  logic [12:0]        yy;
  logic [COL_W-1:0]   xx;
  logic [COL_W-1:0]   wr_col;

  logic             done;
  logic [COL_W-1:0] oc_n;
  logic [ROW_W-1:0] or_n;
  logic             out_take;

  // Effective image size and window geometry.
  always_comb begin
    if (image_width == 12'd0) wm1 = '0;
    else if (image_width > 12'(MAX_LINE)) wm1 = COL_W'(MAX_LINE - 1);
    else wm1 = COL_W'(image_width - 12'd1);
    hm1 = (image_height == 13'd0) ? 13'd0 : image_height - 13'd1;
  end
  assign side_m1 = {window_radius, 1'b0};
  assign side    = side_m1 + 4'd1;
  assign area    = {4'd0, side} * {4'd0, side};

  // Clamped tap coordinates and line store addresses.
  always_comb begin
    ys = $signed({2'b0, out_row}) + $signed({12'b0, ty}) - $signed({13'b0, window_radius});
    xs = $signed({2'b0, out_col}) + $signed({9'b0, tx}) - $signed({10'b0, window_radius});
    if (ys < 0) yy = '0;
    else if (ys > $signed({3'b0, hm1})) yy = hm1;
    else yy = ys[12:0];
    if (xs < 0) xx = '0;
    else if (xs > $signed({2'b0, wm1})) xx = wm1;
    else xx = xs[COL_W-1:0];
    wr_col = (in_col < wm1) ? in_col : wm1;
  end
  assign rd_addr = {mod15(yy), xx};
  assign wr_addr = {mod15(in_row[12:0]), wr_col};

  // Status towards the controller.
  assign done     = ({1'b0, out_row} == {2'b0, hm1}) && (out_col == wm1);
  assign oc_n     = (out_col == wm1) ? '0 : out_col + 1'b1;
  assign or_n     = (out_col == wm1) ? out_row + 1'b1 : out_row;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    stat.item_ok   = item_flush ? (in_row > {1'b0, hm1}) : (in_row <= {1'b0, hm1});
    stat.out_ready = win_ready(out_row, out_col, in_row, in_col, window_radius, wm1);
    stat.tap_last  = (tx == side_m1) && (ty == side_m1);
    stat.div_last  = (div_cnt == 4'd15);
    stat.out_busy  = out_valid && out_stall;
    stat.res_last  = done || (nres == 3'd7) ||
                     !win_ready(or_n, oc_n, in_row, in_col, window_radius, wm1);
  end

  // Line store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.check && stat.item_ok && !item_flush) begin
      mem[wr_addr] <= item_pix;
    end
    mem_q <= mem[rd_addr];
  end

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_flush <= cmd_in;
      item_pix   <= {in_red, in_green, in_blue};
    end
  end

  // Window accumulation over the taps, row by row.
  always_ff @(posedge clk) begin
    if (cmd.start_win) begin
      tx    <= '0;
      ty    <= '0;
      sum_b <= '0;
      sum_g <= '0;
      sum_r <= '0;
    end else if (cmd.acc) begin
      sum_b <= sum_b + {8'd0, mem_q[7:0]};
      sum_g <= sum_g + {8'd0, mem_q[15:8]};
      sum_r <= sum_r + {8'd0, mem_q[23:16]};
      if (tx == side_m1) begin
        tx <= '0;
        ty <= ty + 4'd1;
      end else begin
        tx <= tx + 4'd1;
      end
    end
  end

  // Division step count.
  always_ff @(posedge clk) begin
    if (cmd.div_load) div_cnt <= '0;
    else if (cmd.div_step) div_cnt <= div_cnt + 4'd1;
  end

  rbmf_divider u_div_b (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                        .dividend(sum_b), .divisor(area), .quotient(q_b));
  rbmf_divider u_div_g (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                        .dividend(sum_g), .divisor(area), .quotient(q_g));
  rbmf_divider u_div_r (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                        .dividend(sum_r), .divisor(area), .quotient(q_r));

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_blue    <= q_b;
      out_green   <= q_g;
      out_red     <= q_r;
      last_of_run <= stat.res_last;
      frame_done  <= done;
    end
  end

  // Configuration registers and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 12'd640;
      image_height  <= 13'd480;
      window_radius <= 3'd3;
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
      nres          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width   <= cfg_data[11:0];
        REG_HEIGHT: image_height  <= cfg_data;
        REG_RADIUS: window_radius <= cfg_data[2:0];
        default: ;
      endcase
      if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT || cfg_index == REG_RADIUS) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end
    end else begin
      if (cmd.check) nres <= '0;
      if (cmd.adv_in || (cmd.finish && stat.res_last && !done)) begin
        if (in_col >= wm1) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.finish) begin
        nres <= nres + 3'd1;
        if (done) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else begin
          out_col <= oc_n;
          out_row <= or_n;
        end
      end
    end
  end

endmodule

FILE: hdl/rgb_box_mean_filter.sv
// Top level of the RGB box mean filter: joins the controller and datapath.
// Depends on rbmf_pkg, rbmf_ctrl, rbmf_datapath and rbmf_divider.
//
// Streaming (2r+1)x(2r+1) box mean on BGR pixels in raster order with
// clamp-to-edge borders. Send width*height pixels (cmd 0), then flush words
// (cmd 1) to drive out the bottom rows. Items are handled one at a time: an
// ignored word is captured and checked, a stored word that yields no result
// is also evaluated; each result is paced by the single read port of the
// line store (an address and an accumulate state per tap) and the 16-step
// bit-serial divider. The output register lets the next input word enter
// while a result waits. The line store is not cleared after reset and needs
// no clearing pass. Configuration writes abort the frame in progress.
module rgb_box_mean_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        last_of_run,
  output logic        frame_done
);
  import rbmf_pkg::*;

  cmd_t  ctl_cmd;
  stat_t dp_stat;

  rbmf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(dp_stat), .cmd(ctl_cmd)
  );

  rbmf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(ctl_cmd), .stat(dp_stat),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_in(cmd), .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .last_of_run(last_of_run), .frame_done(frame_done)
  );

endmodule
